// ===== rtl/core/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants of the return series statistics block: request
// structs of both channels, divider request and response, status codes.
// ----------------------------------------------------------------------------
package rss_pkg;

	// fixed point layout
	localparam int FRAC_BITS   = 24;
	localparam int EQ_W        = 48;
	localparam int DD_BITS     = 24;
	localparam int FACTOR_W    = 24;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 24'd1040351;
	localparam logic [EQ_W-1:0] EQ_ONE = 48'h0001_0000_0000;

	// shared divider geometry
	localparam int DVD_W  = 80;
	localparam int DEN_W  = 48;
	localparam int STEP_W = 7;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NONPOS   = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;
	localparam logic [1:0] STAT_TOO_MANY = 2'd3;

	typedef struct packed {
		logic signed [31:0] period_ret;
		logic               last;
	} ret_item_t;

	typedef struct packed {
		logic signed [31:0] equity_gain;
		logic [30:0]        volatility;
		logic signed [31:0] sharpe;
		logic [24:0]        max_drawdown;
		logic [12:0]        sample_count;
		logic [1:0]         status;
	} res_item_t;

	typedef struct packed {
		logic              start;
		logic [DEN_W-1:0]  rem_init;
		logic [DVD_W-1:0]  dividend;
		logic [DEN_W-1:0]  divisor;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quo;
		logic             rem_nz;
	} div_rsp_t;

endpackage

// ===== rtl/core/rss_store.sv =====
// ----------------------------------------------------------------------------
// rss_store
// Return memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rss_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data
);

	logic [31:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/rss_div.sv =====
// ----------------------------------------------------------------------------
// rss_div
// Shared restoring divider, one quotient bit per cycle. The dividend is
// consumed from its top bit; the partial remainder starts at rem_init.
// ----------------------------------------------------------------------------
module rss_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rss_pkg::div_req_t req,
	output rss_pkg::div_rsp_t rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [rss_pkg::STEP_W-1:0]      left_q;
	logic [rss_pkg::DEN_W-1:0]       rem_q;
	logic [rss_pkg::DVD_W-1:0]       dvd_q;
	logic [rss_pkg::DVD_W-1:0]       quo_q;
	logic [rss_pkg::DEN_W-1:0]       den_q;
	logic [rss_pkg::DEN_W:0]         rem_sh;
	logic                            ge;
	logic [rss_pkg::DEN_W-1:0]       rem_nx;

	// one trial subtraction
	always_comb begin
		rem_sh = {rem_q, dvd_q[rss_pkg::DVD_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rss_pkg::DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[rss_pkg::DEN_W-1:0];
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				left_q <= req.steps;
			end else if (busy_q) begin
				left_q <= left_q - 1'b1;
				if (left_q == rss_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvd_q <= req.dividend;
			den_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[rss_pkg::DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[rss_pkg::DVD_W-2:0], ge};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.quo    = quo_q;
	assign rsp.rem_nz = rem_q != '0;

endmodule

// ===== rtl/core/rss_sqrt.sv =====
// ----------------------------------------------------------------------------
// rss_sqrt
// Truncating integer square root of a 64-bit value,
// two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rss_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] x_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// one root digit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= value;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (x_q >= trial) begin
				x_q   <= x_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

// ===== rtl/core/return_series_statistics.sv =====
// ----------------------------------------------------------------------------
// return_series_statistics
// Compounds equity over a series of Q7.24 returns, tracks peak and maximum
// drawdown, keeps each valid return in memory and, on the last return, gives
// total return, annualized volatility, Sharpe ratio and maximum drawdown.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+---------------------------------
//  ret      | in  | ret_valid / ret_ready | ret_item (period_ret, last)
//  res      | out | res_valid / res_ready | res_item (statistics, status)
//  cfg      | in  | cfg_valid / cfg_ready | cfg_data (annualize factor)
//
//  a return runs through two 24x32 partial products and the equity check,
//  plus a 24-step drawdown division when equity sits below its peak
//  the last return then runs the mean division, one memory read per stored
//  return, the variance division, the square root and the Sharpe division,
//  the divisions through the one shared divider
//  reset clears the series state; the memory needs no clearing
//  ret_ready is low while an item is in work; a result waiting on res_ready
//  only stalls the block once the next series is finished
// ----------------------------------------------------------------------------
module return_series_statistics #(
	parameter int MAX_SAMPLES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                ret_valid,
	output logic                ret_ready,
	input  rss_pkg::ret_item_t  ret_item,
	output logic                res_valid,
	input  logic                res_ready,
	output rss_pkg::res_item_t  res_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [23:0]         cfg_data
);

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MUL_LO = 4'd1;
	localparam logic [3:0] ST_MUL_HI = 4'd2;
	localparam logic [3:0] ST_EQ_CHK = 4'd3;
	localparam logic [3:0] ST_DD_W   = 4'd4;
	localparam logic [3:0] ST_FIN    = 4'd5;
	localparam logic [3:0] ST_MEAN_W = 4'd6;
	localparam logic [3:0] ST_VAR    = 4'd7;
	localparam logic [3:0] ST_VAR_W  = 4'd8;
	localparam logic [3:0] ST_SQRT_W = 4'd9;
	localparam logic [3:0] ST_VOL    = 4'd10;
	localparam logic [3:0] ST_AMUL   = 4'd11;
	localparam logic [3:0] ST_SHP_GO = 4'd12;
	localparam logic [3:0] ST_SHP_W  = 4'd13;
	localparam logic [3:0] ST_EMIT   = 4'd14;

	logic [3:0]                state_q;
	logic [CW-1:0]             count_q;
	logic [47:0]               equity_q;
	logic [47:0]               peak_q;
	logic [24:0]               worst_q;
	logic signed [47:0]        sum_q;
	logic [1:0]                err_q;
	logic [23:0]               factor_q;
	logic signed [31:0]        rv_q;
	logic                      last_q;
	logic [31:0]               g_q;
	logic [55:0]               pl_q;
	logic [55:0]               ph_q;
	logic signed [32:0]        mean_q;
	logic [31:0]               mmag_q;
	logic                      mneg_q;
	logic [CW-1:0]             idx_q;
	logic [79:0]               acc_q;
	logic                      rd_v_s1;
	logic                      v_s2;
	logic                      v_s3;
	logic [31:0]               mag_s2;
	logic [63:0]               sq_s3;
	logic [31:0]               sd_q;
	logic [30:0]               vol_q;
	logic [55:0]               a_q;
	logic signed [31:0]        shp_q;
	logic                      sq_start_q;
	logic [63:0]               var_q;
	rss_pkg::div_req_t         div_req_q;
	rss_pkg::div_rsp_t         div_rsp;
	rss_pkg::res_item_t        res_q;
	logic                      res_valid_q;

	logic signed [32:0]        growth;
	logic [56:0]               eq_sum;
	logic [47:0]               new_peak;
	logic                      eq_ok;
	logic                      st_we;
	logic                      rd_en;
	logic [31:0]               rd_data;
	logic signed [33:0]        dvar;
	logic [33:0]               dmag;
	logic                      sqrt_done;
	logic [31:0]               sqrt_root;
	logic                      emit_fire;
	logic                      acc_clr;
	logic                      pipe_idle;
	logic [47:0]               sum_mag;
	logic [32:0]               mean_mag;
	logic [55:0]               vol_prod;
	logic [63:0]               shp_quo;
	logic signed [48:0]        tr_diff;
	logic signed [40:0]        tr_shift;
	logic signed [31:0]        tr_sat;
	logic                      ret_fire;

	// handshakes
	assign ret_ready = state_q == ST_IDLE;
	assign ret_fire  = ret_valid && ret_ready;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;
	assign emit_fire = (state_q == ST_EMIT) && (!res_valid_q || res_ready);

	// growth factor and compounded equity
	always_comb begin
		growth   = $signed({ret_item.period_ret[31], ret_item.period_ret})
		           + 33'sd16777216;
		eq_sum   = {1'b0, ph_q} + {25'b0, pl_q[55:24]};
		eq_ok    = (eq_sum[56:48] == '0) && (eq_sum[47:0] != '0);
		new_peak = (eq_sum[47:0] > peak_q) ? eq_sum[47:0] : peak_q;
		st_we    = (state_q == ST_EQ_CHK) && eq_ok;
	end

	// finish arithmetic
	always_comb begin
		sum_mag  = sum_q[47] ? 48'(-sum_q) : 48'(sum_q);
		mean_mag = 33'(div_rsp.quo[47:0]) + {32'b0, sum_q[47] & div_rsp.rem_nz};
		vol_prod = {24'b0, sd_q} * {32'b0, factor_q};
		shp_quo  = div_rsp.quo[63:0];
		tr_diff  = $signed({1'b0, equity_q}) - $signed({1'b0, rss_pkg::EQ_ONE});
		tr_shift = 41'(tr_diff >>> 8);
		if (tr_shift > 41'sd2147483647) begin
			tr_sat = 32'sh7FFF_FFFF;
		end else if (tr_shift < -41'sd2147483648) begin
			tr_sat = 32'sh8000_0000;
		end else begin
			tr_sat = 32'(tr_shift);
		end
	end

	// control sequencer and series state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			equity_q    <= rss_pkg::EQ_ONE;
			peak_q      <= rss_pkg::EQ_ONE;
			worst_q     <= '0;
			sum_q       <= '0;
			err_q       <= rss_pkg::STAT_OK;
			factor_q    <= rss_pkg::FACTOR_RESET;
			div_req_q   <= '0;
			sq_start_q  <= 1'b0;
			res_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			div_req_q.start <= 1'b0;
			sq_start_q      <= 1'b0;
			if (cfg_valid) begin
				factor_q <= cfg_data;
			end
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (ret_fire) begin
						if (err_q != rss_pkg::STAT_OK) begin
							state_q <= ret_item.last ? ST_FIN : ST_IDLE;
						end else if (count_q == CW'(MAX_SAMPLES)) begin
							err_q   <= rss_pkg::STAT_TOO_MANY;
							state_q <= ret_item.last ? ST_FIN : ST_IDLE;
						end else if (growth <= 33'sd0) begin
							err_q   <= rss_pkg::STAT_NONPOS;
							state_q <= ret_item.last ? ST_FIN : ST_IDLE;
						end else begin
							state_q <= ST_MUL_LO;
						end
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: state_q <= ST_EQ_CHK;
				ST_EQ_CHK: begin
					if (eq_sum[56:48] != '0) begin
						err_q   <= rss_pkg::STAT_OVERFLOW;
						state_q <= last_q ? ST_FIN : ST_IDLE;
					end else if (!eq_ok) begin
						err_q   <= rss_pkg::STAT_NONPOS;
						state_q <= last_q ? ST_FIN : ST_IDLE;
					end else begin
						count_q  <= count_q + 1'b1;
						sum_q    <= sum_q + 48'(rv_q);
						equity_q <= eq_sum[47:0];
						peak_q   <= new_peak;
						if (eq_sum[47:0] < new_peak) begin
							div_req_q.start    <= 1'b1;
							div_req_q.rem_init <= new_peak - eq_sum[47:0];
							div_req_q.dividend <= '0;
							div_req_q.divisor  <= new_peak;
							div_req_q.steps    <= rss_pkg::STEP_W'(rss_pkg::DD_BITS);
							state_q            <= ST_DD_W;
						end else begin
							state_q <= last_q ? ST_FIN : ST_IDLE;
						end
					end
				end
				ST_DD_W: begin
					if (div_rsp.done) begin
						if ({1'b0, div_rsp.quo[23:0]} > worst_q) begin
							worst_q <= {1'b0, div_rsp.quo[23:0]};
						end
						state_q <= last_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (err_q != rss_pkg::STAT_OK || count_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						div_req_q.start    <= 1'b1;
						div_req_q.rem_init <= '0;
						div_req_q.dividend <= {sum_mag, 32'b0};
						div_req_q.divisor  <= 48'(count_q);
						div_req_q.steps    <= rss_pkg::STEP_W'(48);
						state_q            <= ST_MEAN_W;
					end
				end
				ST_MEAN_W: begin
					if (div_rsp.done) begin
						idx_q <= '0;
						if (count_q < CW'(2)) begin
							state_q <= ST_VOL;
						end else begin
							state_q <= ST_VAR;
						end
					end
				end
				ST_VAR: begin
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end else if (pipe_idle) begin
						div_req_q.start    <= 1'b1;
						div_req_q.rem_init <= '0;
						div_req_q.dividend <= acc_q;
						div_req_q.divisor  <= 48'(count_q) - 48'd1;
						div_req_q.steps    <= rss_pkg::STEP_W'(rss_pkg::DVD_W);
						state_q            <= ST_VAR_W;
					end
				end
				ST_VAR_W: begin
					if (div_rsp.done) begin
						sq_start_q <= 1'b1;
						state_q    <= ST_SQRT_W;
					end
				end
				ST_SQRT_W: begin
					if (sqrt_done) begin
						state_q <= ST_VOL;
					end
				end
				ST_VOL: state_q <= (sd_q == '0) ? ST_EMIT : ST_AMUL;
				ST_AMUL: state_q <= ST_SHP_GO;
				ST_SHP_GO: begin
					div_req_q.start    <= 1'b1;
					div_req_q.rem_init <= '0;
					div_req_q.dividend <= {a_q, 24'b0};
					div_req_q.divisor  <= 48'(sd_q);
					div_req_q.steps    <= rss_pkg::STEP_W'(64);
					state_q            <= ST_SHP_W;
				end
				ST_SHP_W: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						res_valid_q <= 1'b1;
						count_q     <= '0;
						equity_q    <= rss_pkg::EQ_ONE;
						peak_q      <= rss_pkg::EQ_ONE;
						worst_q     <= '0;
						sum_q       <= '0;
						err_q       <= rss_pkg::STAT_OK;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// per-item and finish payload registers
	always_ff @(posedge clk) begin
		if (ret_fire) begin
			rv_q   <= ret_item.period_ret;
			last_q <= ret_item.last;
			g_q    <= growth[31:0];
		end
		if (state_q == ST_MUL_LO) begin
			pl_q <= {32'b0, equity_q[23:0]} * {24'b0, g_q};
		end
		if (state_q == ST_MUL_HI) begin
			ph_q <= {32'b0, equity_q[47:24]} * {24'b0, g_q};
		end
		if (state_q == ST_MEAN_W && div_rsp.done) begin
			mneg_q <= sum_q[47];
			mmag_q <= 32'(mean_mag);
			mean_q <= sum_q[47] ? -$signed(mean_mag) : $signed(mean_mag);
			sd_q   <= '0;
		end
		if (state_q == ST_VAR_W && div_rsp.done) begin
			var_q <= (div_rsp.quo[79:64] != '0) ? '1 : div_rsp.quo[63:0];
		end
		if (state_q == ST_SQRT_W && sqrt_done) begin
			sd_q <= sqrt_root;
		end
		if (state_q == ST_VOL) begin
			vol_q <= (vol_prod[55:47] != '0) ? '1 : vol_prod[46:16];
			shp_q <= '0;
		end
		if (state_q == ST_AMUL) begin
			a_q <= {24'b0, mmag_q} * {32'b0, factor_q};
		end
		if (state_q == ST_SHP_W && div_rsp.done) begin
			if (mneg_q) begin
				shp_q <= (shp_quo[63:32] != '0 || shp_quo[31]) ? 32'sh8000_0000
				         : -$signed(shp_quo[31:0]);
			end else begin
				shp_q <= (shp_quo[63:32] != '0 || shp_quo[31]) ? 32'sh7FFF_FFFF
				         : $signed(shp_quo[31:0]);
			end
		end
		if (emit_fire) begin
			res_q.sample_count <= 13'(count_q);
			res_q.status       <= err_q;
			if (err_q != rss_pkg::STAT_OK || count_q == '0) begin
				res_q.equity_gain  <= '0;
				res_q.volatility   <= '0;
				res_q.sharpe       <= '0;
				res_q.max_drawdown <= '0;
			end else begin
				res_q.equity_gain  <= tr_sat;
				res_q.volatility   <= vol_q;
				res_q.sharpe       <= shp_q;
				res_q.max_drawdown <= worst_q;
			end
		end
	end

	// second pass: read, deviation, square, accumulate
	assign rd_en     = (state_q == ST_VAR) && (idx_q < count_q);
	assign pipe_idle = !rd_v_s1 && !v_s2 && !v_s3;
	assign acc_clr   = (state_q == ST_MEAN_W) && div_rsp.done;

	always_comb begin
		dvar = $signed({{2{rd_data[31]}}, rd_data}) - $signed({mean_q[32], mean_q});
		dmag = dvar[33] ? 34'(-dvar) : 34'(dvar);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			rd_v_s1 <= rd_en;
			v_s2    <= rd_v_s1;
			v_s3    <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mag_s2 <= dmag[31:0];
		sq_s3  <= {32'b0, mag_s2} * {32'b0, mag_s2};
		if (acc_clr) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + {16'b0, sq_s3};
		end
	end

	rss_store #(
		.DEPTH (MAX_SAMPLES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (st_we),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (rv_q),
		.rd_en   (rd_en),
		.rd_addr (idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	rss_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	rss_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start_q),
		.value  (var_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// store writes stay inside the memory
	assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> count_q < CW'(MAX_SAMPLES))
		else $error("store write beyond depth");

	// the first error sticks until the result leaves
	assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != rss_pkg::STAT_OK) && !emit_fire |=> err_q == $past(err_q))
		else $error("error code changed inside a series");

	// divider results only arrive where the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DD_W || state_q == ST_MEAN_W ||
		                  state_q == ST_VAR_W || state_q == ST_SHP_W))
		else $error("divider result with no consumer");

	// peak never falls below equity
	assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= equity_q)
		else $error("peak below equity");

endmodule

// ===== tb/sv/return_stats_checker.sv =====
// ----------------------------------------------------------------------------
// return_stats_checker
// Watches the return, result and factor channels of the return series
// statistics block. Every accepted return runs through an independent
// predictor of equity, drawdown, mean, deviation and Sharpe ratio. Every
// accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module return_stats_checker #(
	parameter int SERIES_LIMIT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ret_valid,
	input  logic               ret_ready,
	input  rss_pkg::ret_item_t ret_item,
	input  logic               res_valid,
	input  logic               res_ready,
	input  rss_pkg::res_item_t res_item,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [23:0]        cfg_data,
	output int                 mismatch_count,
	output int                 pending_results
);

	localparam logic [47:0] EQUITY_MAX = 48'hFFFF_FFFF_FFFF;

	// series state of the predictor
	logic [47:0]        equity;
	logic [47:0]        peak;
	logic [24:0]        worst_dd;
	logic signed [63:0] return_total;
	int                 n_returns;
	logic [1:0]         series_status;
	logic [23:0]        factor;
	logic signed [31:0] series_returns[$];
	rss_pkg::res_item_t expected_stats[$];

	function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (64'(trial) * 64'(trial) <= x)
				root = trial;
		end
		return root;
	endfunction

	task automatic clear_series();
		equity        = rss_pkg::EQ_ONE;
		peak          = rss_pkg::EQ_ONE;
		worst_dd      = '0;
		return_total  = '0;
		n_returns     = 0;
		series_status = rss_pkg::STAT_OK;
		series_returns.delete();
	endtask

	// closes the series and queues the statistics it predicts
	task automatic close_series();
		rss_pkg::res_item_t r;
		logic signed [63:0] mean;
		logic signed [63:0] gain;
		logic signed [63:0] dev;
		logic [127:0]       sq_sum;
		logic [127:0]       var_wide;
		logic [63:0]        variance;
		logic [63:0]        sd;
		logic [63:0]        vol;
		logic [63:0]        mean_mag;
		logic [127:0]       ratio;
		r = '0;
		if (series_status == rss_pkg::STAT_OK && n_returns > 0) begin
			mean = return_total / n_returns;
			if (return_total < 0 && mean * n_returns != return_total)
				mean = mean - 1;
			gain = $signed({16'd0, equity}) - $signed({16'd0, rss_pkg::EQ_ONE});
			gain = gain >>> 8;
			if (gain > 64'sd2147483647)
				r.equity_gain = 32'h7FFF_FFFF;
			else if (gain < -64'sd2147483648)
				r.equity_gain = 32'h8000_0000;
			else
				r.equity_gain = gain[31:0];
			sd = '0;
			if (n_returns >= 2) begin
				sq_sum = '0;
				foreach (series_returns[i]) begin
					dev = 64'(series_returns[i]) - mean;
					if (dev < 0)
						dev = -dev;
					sq_sum += 128'(dev) * 128'(dev);
				end
				var_wide = sq_sum / (n_returns - 1);
				variance = (var_wide > 128'(64'hFFFF_FFFF_FFFF_FFFF)) ?
					64'hFFFF_FFFF_FFFF_FFFF : var_wide[63:0];
				sd = 64'(floor_sqrt(variance));
			end
			vol = (sd * 64'(factor)) >> 16;
			r.volatility = (vol > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : vol[30:0];
			if (sd != 0) begin
				mean_mag = (mean < 0) ? 64'(-mean) : 64'(mean);
				ratio = ((128'(mean_mag) * 128'(factor)) << (rss_pkg::FRAC_BITS - 16))
					/ 128'(sd);
				if (mean < 0)
					r.sharpe = (ratio >= 128'h8000_0000) ? 32'h8000_0000 : -ratio[31:0];
				else
					r.sharpe = (ratio > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : ratio[31:0];
			end
			r.max_drawdown = worst_dd;
		end
		r.sample_count = n_returns[12:0];
		r.status       = series_status;
		expected_stats.insert(expected_stats.size(), r);
		clear_series();
	endtask

	// one accepted return: compound, track peak and drawdown, keep the return
	task automatic take_return(input rss_pkg::ret_item_t it);
		logic signed [63:0] growth;
		logic [95:0]        grown;
		logic [47:0]        next_eq;
		logic [95:0]        dd;
		if (series_status == rss_pkg::STAT_OK) begin
			growth = (64'sd1 <<< rss_pkg::FRAC_BITS) + 64'(it.period_ret);
			if (n_returns >= SERIES_LIMIT) begin
				series_status = rss_pkg::STAT_TOO_MANY;
			end else if (growth <= 0) begin
				series_status = rss_pkg::STAT_NONPOS;
			end else begin
				grown = (96'(equity) * 96'(growth)) >> rss_pkg::FRAC_BITS;
				if (grown > 96'(EQUITY_MAX)) begin
					series_status = rss_pkg::STAT_OVERFLOW;
				end else if (grown == 0) begin
					series_status = rss_pkg::STAT_NONPOS;
				end else begin
					next_eq = grown[47:0];
					series_returns.insert(series_returns.size(), it.period_ret);
					n_returns++;
					return_total += 64'(it.period_ret);
					equity = next_eq;
					if (next_eq > peak)
						peak = next_eq;
					dd = (96'(peak - next_eq) << rss_pkg::DD_BITS) / 96'(peak);
					if (dd[24:0] > worst_dd)
						worst_dd = dd[24:0];
				end
			end
		end
		if (it.last)
			close_series();
	endtask

	task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
		$display("%0t mismatch in %s: expected %0h, actual %0h", $time, field, want, got);
	endtask

	// compare each delivered result with the oldest prediction
	task automatic check_result(input rss_pkg::res_item_t got);
		rss_pkg::res_item_t want;
		if (expected_stats.size() == 0) begin
			$display("%0t unexpected result: %p", $time, got);
			mismatch_count++;
			return;
		end
		want = expected_stats.pop_front();
		if (got != want) begin
			mismatch_count++;
			if (got.equity_gain != want.equity_gain)
				report("equity_gain", want.equity_gain, got.equity_gain);
			if (got.volatility != want.volatility)
				report("volatility", 32'(want.volatility), 32'(got.volatility));
			if (got.sharpe != want.sharpe)
				report("sharpe", want.sharpe, got.sharpe);
			if (got.max_drawdown != want.max_drawdown)
				report("max_drawdown", 32'(want.max_drawdown), 32'(got.max_drawdown));
			if (got.sample_count != want.sample_count)
				report("sample_count", 32'(want.sample_count), 32'(got.sample_count));
			if (got.status != want.status)
				report("status", 32'(want.status), 32'(got.status));
		end
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_series();
			expected_stats.delete();
			factor          = rss_pkg::FACTOR_RESET;
			mismatch_count  = 0;
			pending_results = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				factor = cfg_data;
			if (ret_valid && ret_ready)
				take_return(ret_item);
			if (res_valid && res_ready)
				check_result(res_item);
			pending_results = expected_stats.size();
		end
	end

endmodule

// ===== tb/sv/return_series_statistics_test.sv =====
// ----------------------------------------------------------------------------
// return_series_statistics_test
// Drives return series into the statistics block: directed corner series
// (extreme returns, error cases, flat and saturating series), then random
// series under three idle patterns and a long result stall, with factor
// writes between phases. The checker judges the results.
// ----------------------------------------------------------------------------
module return_series_statistics_test;

	localparam int ONE_Q = 1 << rss_pkg::FRAC_BITS;

	logic               clk;
	logic               arst_n;
	logic               ret_valid;
	logic               ret_ready;
	rss_pkg::ret_item_t ret_item;
	logic               res_valid;
	logic               res_ready;
	rss_pkg::res_item_t res_item;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [23:0]        cfg_data;
	int                 mismatch_count;
	int                 pending_results;

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;

	return_series_statistics dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ret_valid (ret_valid),
		.ret_ready (ret_ready),
		.ret_item  (ret_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	return_stats_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.ret_valid       (ret_valid),
		.ret_ready       (ret_ready),
		.ret_item        (ret_item),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res_item        (res_item),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		#40000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// result receiver with random stalls and one long hold-off
	initial begin
		bit held;
		held = 1'b0;
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				res_ready <= 1'b0;
				repeat (3000) @(negedge clk);
			end
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_return(input logic signed [31:0] value, input logic last_flag);
		while ($urandom_range(99) < send_idle_pct) begin
			ret_valid <= 1'b0;
			@(negedge clk);
		end
		ret_valid <= 1'b1;
		ret_item  <= '{period_ret: value, last: last_flag};
		do @(posedge clk); while (!ret_ready);
		@(negedge clk);
	endtask

	// wait for all results, then for the block to settle
	task automatic drain();
		ret_valid <= 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_factor(input logic [23:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] random_return();
		case ($urandom_range(9))
			0: return $urandom;
			1: return -ONE_Q + $urandom_range(1 << 20);
			default: return $signed($urandom_range(1 << 23)) - (1 << 22);
		endcase
	endfunction

	// random series, mostly well formed with the odd stray last
	task automatic random_series(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(12, 1);
			for (int i = 0; i < len; i++) begin
				send_return(random_return(), (i == len - 1) || ($urandom_range(29) == 0));
				sent++;
			end
		end
	endtask

	initial begin
		ret_valid     = 1'b0;
		ret_item      = '0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		hold_req      = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n        = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// short series and extreme growth
		send_return(32'sd1 << 20, 1'b1);
		send_return(32'sh7FFF_FFFF, 1'b0);
		send_return(-(32'sd1 << 22), 1'b1);
		// overflow, then ignored returns after the error
		send_return(32'sh7FFF_FFFF, 1'b0);
		send_return(32'sh7FFF_FFFF, 1'b0);
		send_return(32'sh7FFF_FFFF, 1'b0);
		send_return(32'sd5, 1'b1);
		// most negative return and exactly minus one
		send_return(32'sh8000_0000, 1'b1);
		send_return(-ONE_Q, 1'b1);
		// equity truncating to zero
		send_return(-ONE_Q + 1, 1'b0);
		send_return(-ONE_Q + 1, 1'b1);
		// drawdown and negative mean
		send_return(ONE_Q / 2, 1'b0);
		send_return(-ONE_Q / 2, 1'b0);
		send_return(-ONE_Q / 4, 1'b1);
		// flat series: zero deviation
		send_return(32'sd1000, 1'b0);
		send_return(32'sd1000, 1'b1);
		// tiny deviation, large mean: saturating ratio of both signs
		send_return(32'sd1 << 23, 1'b0);
		send_return((32'sd1 << 23) + 1, 1'b1);
		send_return(-(32'sd1 << 23), 1'b0);
		send_return(-(32'sd1 << 23) - 1, 1'b1);
		drain();

		// factor extremes
		write_factor(24'd0);
		random_series(20);
		drain();
		write_factor(24'hFF_FFFF);
		send_return(32'sd1 << 23, 1'b0);
		send_return(-(32'sd1 << 23), 1'b1);
		random_series(20);
		drain();

		// random phases under varying idle patterns
		write_factor(24'($urandom_range(24'hFF_FFFF)));
		send_idle_pct = 6;
		recv_idle_pct = 58;
		random_series(145);
		drain();
		write_factor(rss_pkg::FACTOR_RESET);
		send_idle_pct = 58;
		recv_idle_pct = 6;
		random_series(145);
		drain();
		write_factor(24'($urandom_range(24'hFF_FFFF)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		random_series(145);
		drain();

		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
